FILE: hdl/b64e_pkg.sv
// Shared types, constants and the symbol mapping for the base64 stream encoder.
`timescale 1ns / 1ps

package b64e_pkg;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	localparam logic [7:0] CH_PAD   = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;
	localparam logic [7:0] CH_DIGIT = 8'h30;

	localparam logic [5:0] SYM_PLUS  = 6'd62;
	localparam logic [5:0] SYM_SLASH = 6'd63;
	localparam logic [5:0] SYM_UPPER_MAX = 6'd25;
	localparam logic [5:0] SYM_LOWER_MAX = 6'd51;
	localparam logic [7:0] LOWER_BASE = 8'd26;
	localparam logic [7:0] DIGIT_BASE = 8'd52;

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2,
		PH_UNUSED = 2'd3
	} phase_t;

	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            fin;
	} entry_t;

	function automatic logic [7:0] b64_symbol(input logic [5:0] v);
		logic [7:0] r;
		case (v) inside
			SYM_PLUS:               r = CH_PLUS;
			SYM_SLASH:              r = CH_SLASH;
			[6'd0:SYM_UPPER_MAX]:   r = CH_UPPER + {2'b00, v};
			[6'd26:SYM_LOWER_MAX]:  r = CH_LOWER + ({2'b00, v} - LOWER_BASE);
			default:                r = CH_DIGIT + ({2'b00, v} - DIGIT_BASE);
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/b64e_front.sv
// Front end: takes bytes, tracks the group phase and builds character entries.
`timescale 1ns / 1ps

module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	output b64e_pkg::entry_t  entry
);
	import b64e_pkg::*;

	phase_t     phase_q;
	logic [3:0] leftover_q;
	phase_t     nphase;
	logic [3:0] nleft;

	always_comb begin
		entry = '0;
		nphase = PH_START;
		nleft = '0;
		case (phase_q)
			PH_SECOND: begin
				entry.chars[0] = b64_symbol({leftover_q[1:0], data_byte[7:4]});
				nleft = data_byte[3:0];
				nphase = PH_THIRD;
				entry.last_idx = 2'd0;
			end
			PH_THIRD: begin
				entry.chars[0] = b64_symbol({leftover_q[3:0], data_byte[7:6]});
				entry.chars[1] = b64_symbol(data_byte[5:0]);
				nleft = '0;
				nphase = PH_START;
				entry.last_idx = 2'd1;
			end
			default: begin
				entry.chars[0] = b64_symbol(data_byte[7:2]);
				nleft = {2'b00, data_byte[1:0]};
				nphase = PH_SECOND;
				entry.last_idx = 2'd0;
			end
		endcase
		entry.fin = final_byte;
		if (final_byte) begin
			if (nphase == PH_SECOND) begin
				entry.chars[1] = b64_symbol({nleft[1:0], 4'b0000});
				entry.chars[2] = CH_PAD;
				entry.chars[3] = CH_PAD;
				entry.last_idx = 2'd3;
			end else if (nphase == PH_THIRD) begin
				entry.chars[1] = b64_symbol({nleft[3:0], 2'b00});
				entry.chars[2] = CH_PAD;
				entry.last_idx = 2'd2;
			end
			nphase = PH_START;
			nleft = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			leftover_q <= '0;
		end else if (push) begin
			phase_q <= nphase;
			leftover_q <= nleft;
		end
	end

endmodule

FILE: hdl/b64e_fifo.sv
// Short entry queue between the front end and the character serializer.
`timescale 1ns / 1ps

module b64e_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64e_pkg::entry_t  wr_entry,
	output logic              full,
	input  logic              pop,
	output b64e_pkg::entry_t  rd_entry,
	output logic              empty
);
	import b64e_pkg::*;

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue count exceeds depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");

endmodule

FILE: hdl/b64e_back.sv
// Back end: serializes queued entries into one output character per cycle unless char_stall holds it.
`timescale 1ns / 1ps

module b64e_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64e_pkg::entry_t  head,
	input  logic              empty,
	output logic              pop,
	output logic              char_valid,
	input  logic              char_stall,
	output logic [7:0]        out_char,
	output logic              last_char
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       advance;
	logic       at_end;

	assign advance = !char_valid || !char_stall;
	assign at_end = (idx_q == head.last_idx);
	assign pop = advance && !empty && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			idx_q <= '0;
		end else if (advance) begin
			char_valid <= !empty;
			if (!empty) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !empty) begin
			out_char <= head.chars[idx_q];
			last_char <= head.fin && at_end;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q <= head.last_idx))
		else $error("character index beyond entry length");

	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 2'd0))
		else $error("character index not cleared after pop");

endmodule

FILE: hdl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder.
`timescale 1ns / 1ps

// Streaming base64 encoder, standard alphabet with '=' padding. One byte is
// taken per transaction on the data channel; final_byte closes the message,
// which flushes the leftover bits, appends the padding and flags the last
// character with last_char. Characters leave one per cycle from the output
// register unless char_stall holds it, so that register sets the rate:
// four characters per three bytes, up to four for a final byte. An accepted
// byte is written into the queue, then registered as a character in the
// output register. A four-entry queue separates byte intake from output,
// so bytes are taken while characters wait on char_stall, until it is full.
module base64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [7:0] out_char,
	output logic       last_char
);
	import b64e_pkg::*;

	entry_t wr_entry;
	entry_t rd_entry;
	logic   full;
	logic   empty;
	logic   pop;
	logic   push;

	assign data_stall = full;
	assign push = data_valid && !full;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.entry      (wr_entry)
	);

	b64e_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.rd_entry (rd_entry),
		.empty    (empty)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (rd_entry),
		.empty      (empty),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

endmodule
